@@ sv/npp_pkg.sv @@
package npp_pkg;

    // item kinds carried on s_tuser
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_APPEND = 2'd1,
        OP_SUBMIT = 2'd2
    } op_t;

    // configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_AUDIO_ENABLE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_ENABLE = 1'd1;

    localparam int FREQ_W  = 16;
    localparam int TIME_W  = 16;
    localparam int COLOR_W = 24;
    localparam int FLASH_W = 8;
    localparam int OP_W    = 2;
    localparam int IN_W    = 96;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [TIME_W-1:0] dur;
    } note_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [FLASH_W-1:0] flashes;
        logic [TIME_W-1:0]  on_time;
        logic [TIME_W-1:0]  off_time;
    } light_t;

    function automatic logic [TIME_W-1:0] sat_inc_time(input logic [TIME_W-1:0] v);
        return (v == {TIME_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [FLASH_W-1:0] sat_inc_flash(input logic [FLASH_W-1:0] v);
        return (v == {FLASH_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

@@ sv/notification_pattern_player.sv @@
// timing: a result item is registered in the cycle after its input item is accepted
// throughput: one item per cycle unless a full result register is held by m_tready low,
// set by the single state update before the result register, which frees the input side
// reset: aresetn is synchronous and active low; queue and player go idle, both enables to 1
// no clearing pass after reset: queue memories are only read after being written
module notification_pattern_player #(
    parameter int QUEUE_DEPTH = 8,
    parameter int MAX_NOTES   = 8,
    localparam int LVL_W  = $clog2(QUEUE_DEPTH + 1),
    localparam int OUT_W  = ((42 + LVL_W + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // note_frequency, note_duration, flash_color, flash_total, flash_on_time, flash_off_time
    input  logic [npp_pkg::IN_W-1:0]        s_tdata,
    // operation
    input  logic [npp_pkg::OP_W-1:0]        s_tuser,
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tone_hz, led_rgb, busy_res, accepted, queue_level, zero fill
    output logic [OUT_W-1:0]                m_tdata,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [npp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic                            cfg_wr_data
);

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(MAX_NOTES + 1);
    localparam int NIDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int PAD_W  = OUT_W - 42 - LVL_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);

    // unpacked input item
    npp_pkg::op_t                    op;
    npp_pkg::note_t                  in_note;
    npp_pkg::light_t                 in_light;
    logic                            in_fire;

    // configuration
    logic                            audio_en_reg;
    logic                            light_en_reg;

    // queue storage: one row of notes, a note count and a light setup per slot
    npp_pkg::note_t [MAX_NOTES-1:0]  notes_mem [QUEUE_DEPTH];
    logic [CNT_W-1:0]                cnt_mem   [QUEUE_DEPTH];
    npp_pkg::light_t                 light_mem [QUEUE_DEPTH];
    // registered read of the slot at the queue head
    npp_pkg::note_t [MAX_NOTES-1:0]  head_notes_reg;
    logic [CNT_W-1:0]                head_cnt_reg;
    npp_pkg::light_t                 head_light_reg;

    logic [SLOT_W-1:0]               head_reg, head_next;
    logic [SLOT_W-1:0]               tail_reg, tail_next;
    logic [LVL_W-1:0]                waiting_reg, waiting_next;
    logic [CNT_W-1:0]                build_reg, build_next;

    // pattern now playing; notes sit in a shift line with the current note in tap 0
    npp_pkg::note_t                  taps_reg [MAX_NOTES+1];
    logic [CNT_W-1:0]                cur_cnt_reg, cur_cnt_next;
    npp_pkg::light_t                 cur_light_reg, cur_light_next;
    logic                            playing_reg, playing_next;
    logic [CNT_W-1:0]                idx_reg, idx_next;
    logic [npp_pkg::TIME_W-1:0]      note_el_reg, note_el_next;
    logic                            lit_reg, lit_next;
    logic [npp_pkg::FLASH_W-1:0]     fc_reg, fc_next;
    logic [npp_pkg::TIME_W-1:0]      led_el_reg, led_el_next;
    logic [npp_pkg::FREQ_W-1:0]      tone_reg, tone_next;
    logic [npp_pkg::COLOR_W-1:0]     led_reg, led_next;

    // control from the update logic
    logic                            note_wr;
    logic                            meta_wr;
    logic                            notes_load;
    logic                            notes_shift;
    logic                            start_req;
    logic                            ok;
    logic                            audio_done;
    logic                            light_done;
    logic [NIDX_W-1:0]               lane;
    logic [CNT_W-1:0]                start_cnt;
    npp_pkg::light_t                 start_light;

    // result register
    logic                            m_valid_reg;
    logic [OUT_W-1:0]                m_data_reg;
    logic [OUT_W-1:0]                out_next;

    assign op       = npp_pkg::op_t'(s_tuser);
    // frequency sits in the low half of the bus, but in the high half of a stored note
    assign in_note  = {s_tdata[15:0], s_tdata[31:16]};
    assign in_light = {s_tdata[55:32], s_tdata[63:56], s_tdata[79:64], s_tdata[95:80]};
    // a new item goes in whenever the result register is empty or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign lane     = build_reg[NIDX_W-1:0];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            audio_en_reg <= 1'b1;
            light_en_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                npp_pkg::REG_AUDIO_ENABLE: audio_en_reg <= cfg_wr_data;
                npp_pkg::REG_LIGHT_ENABLE: light_en_reg <= cfg_wr_data;
            endcase
        end
    end

    // queue memories, read at the next head with the same-cycle write forwarded
    always_ff @(posedge aclk) begin
        if (note_wr) begin
            notes_mem[tail_reg][lane] <= in_note;
        end
        if (note_wr && (tail_reg == head_next)) begin
            for (int i = 0; i < MAX_NOTES; i++) begin
                head_notes_reg[i] <= (i == int'(lane)) ? in_note : notes_mem[head_next][i];
            end
        end else begin
            head_notes_reg <= notes_mem[head_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (meta_wr) begin
            cnt_mem[tail_reg]   <= build_reg;
            light_mem[tail_reg] <= in_light;
        end
        if (meta_wr && (tail_reg == head_next)) begin
            head_cnt_reg   <= build_reg;
            head_light_reg <= in_light;
        end else begin
            head_cnt_reg   <= cnt_mem[head_next];
            head_light_reg <= light_mem[head_next];
        end
    end

    // note shift line: loaded at pattern start, one step per finished note
    always_ff @(posedge aclk) begin
        if (notes_load) begin
            for (int i = 0; i < MAX_NOTES; i++) begin
                taps_reg[i] <= head_notes_reg[i];
            end
            taps_reg[MAX_NOTES] <= '0;
        end else if (notes_shift) begin
            for (int i = 0; i < MAX_NOTES; i++) begin
                taps_reg[i] <= taps_reg[i+1];
            end
            taps_reg[MAX_NOTES] <= '0;
        end
    end

    // a submit while idle starts its own pattern, so its setup comes straight from the item
    always_comb begin
        if (op == npp_pkg::OP_SUBMIT) begin
            start_cnt   = build_reg;
            start_light = in_light;
        end else begin
            start_cnt   = head_cnt_reg;
            start_light = head_light_reg;
        end
    end

    // state update for one item
    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        waiting_next   = waiting_reg;
        build_next     = build_reg;
        cur_cnt_next   = cur_cnt_reg;
        cur_light_next = cur_light_reg;
        playing_next   = playing_reg;
        idx_next       = idx_reg;
        note_el_next   = note_el_reg;
        lit_next       = lit_reg;
        fc_next        = fc_reg;
        led_el_next    = led_el_reg;
        tone_next      = tone_reg;
        led_next       = led_reg;
        note_wr        = 1'b0;
        meta_wr        = 1'b0;
        notes_load     = 1'b0;
        notes_shift    = 1'b0;
        start_req      = 1'b0;
        ok             = 1'b0;
        audio_done     = 1'b0;
        light_done     = 1'b0;

        if (in_fire) begin
            unique case (op)
                npp_pkg::OP_TICK: begin
                    if (playing_reg) begin
                        note_el_next = npp_pkg::sat_inc_time(note_el_reg);
                        led_el_next  = npp_pkg::sat_inc_time(led_el_reg);

                        // audio: advance to the next note once this one has run out
                        if (audio_en_reg && (idx_reg < cur_cnt_reg)) begin
                            if (note_el_next >= taps_reg[0].dur) begin
                                idx_next     = idx_reg + 1'b1;
                                note_el_next = '0;
                                notes_shift  = 1'b1;
                                tone_next    = (idx_next < cur_cnt_reg) ? taps_reg[1].freq : '0;
                            end
                        end

                        // light: on phase ends a flash, off phase starts the next one
                        if (light_en_reg && (cur_light_reg.flashes != '0)) begin
                            if (lit_reg) begin
                                if (led_el_next >= cur_light_reg.on_time) begin
                                    led_next    = '0;
                                    lit_next    = 1'b0;
                                    fc_next     = npp_pkg::sat_inc_flash(fc_reg);
                                    led_el_next = '0;
                                end
                            end else if ((fc_reg < cur_light_reg.flashes) &&
                                         (led_el_next >= cur_light_reg.off_time)) begin
                                led_next    = cur_light_reg.color;
                                lit_next    = 1'b1;
                                led_el_next = '0;
                            end
                        end

                        audio_done = !audio_en_reg || (idx_next >= cur_cnt_reg);
                        light_done = !light_en_reg || (cur_light_reg.flashes == '0) ||
                                     ((fc_next >= cur_light_reg.flashes) && !lit_next);
                        start_req  = audio_done && light_done;
                    end
                end
                npp_pkg::OP_APPEND: begin
                    // notes past the limit or into a full queue are dropped
                    if ((build_reg < CNT_W'(MAX_NOTES)) &&
                        (waiting_reg < LVL_W'(QUEUE_DEPTH))) begin
                        note_wr    = 1'b1;
                        build_next = build_reg + 1'b1;
                    end
                end
                npp_pkg::OP_SUBMIT: begin
                    build_next = '0;
                    if (waiting_reg < LVL_W'(QUEUE_DEPTH)) begin
                        meta_wr      = 1'b1;
                        tail_next    = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
                        waiting_next = waiting_reg + 1'b1;
                        ok           = 1'b1;
                        start_req    = !playing_reg;
                    end
                end
                default: begin
                end
            endcase

            // take the next pattern from the queue, or go idle when it is empty
            if (start_req) begin
                if (waiting_next == '0) begin
                    playing_next = 1'b0;
                    tone_next    = '0;
                    led_next     = '0;
                    lit_next     = 1'b0;
                end else begin
                    notes_load     = 1'b1;
                    notes_shift    = 1'b0;
                    cur_cnt_next   = start_cnt;
                    cur_light_next = start_light;
                    head_next      = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                    waiting_next   = waiting_next - 1'b1;
                    playing_next   = 1'b1;
                    idx_next       = '0;
                    note_el_next   = '0;
                    fc_next        = '0;
                    led_el_next    = '0;
                    lit_next       = 1'b0;
                    tone_next      = (audio_en_reg && (start_cnt != '0)) ?
                                     head_notes_reg[0].freq : '0;
                    if (light_en_reg && (start_light.flashes != '0)) begin
                        led_next = start_light.color;
                        lit_next = 1'b1;
                    end
                end
            end
        end
    end

    // result packing; the tone is muted while audio is off
    always_comb begin
        out_next = {{PAD_W{1'b0}}, waiting_next, ok, playing_next, led_next,
                    (audio_en_reg ? tone_next : {npp_pkg::FREQ_W{1'b0}})};
    end

    // control and player state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            waiting_reg   <= '0;
            build_reg     <= '0;
            cur_cnt_reg   <= '0;
            cur_light_reg <= '0;
            playing_reg   <= 1'b0;
            idx_reg       <= '0;
            note_el_reg   <= '0;
            lit_reg       <= 1'b0;
            fc_reg        <= '0;
            led_el_reg    <= '0;
            tone_reg      <= '0;
            led_reg       <= '0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            waiting_reg   <= waiting_next;
            build_reg     <= build_next;
            cur_cnt_reg   <= cur_cnt_next;
            cur_light_reg <= cur_light_next;
            playing_reg   <= playing_next;
            idx_reg       <= idx_next;
            note_el_reg   <= note_el_next;
            lit_reg       <= lit_next;
            fc_reg        <= fc_next;
            led_el_reg    <= led_el_next;
            tone_reg      <= tone_next;
            led_reg       <= led_next;
        end
    end

    // result register: holds a result until taken, refilled in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_data_reg <= out_next;
        end
    end

`ifndef SYNTH
    // an idle player never leaves patterns waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        !playing_reg |-> (waiting_reg == '0))
        else $error("patterns waiting while player idle");

    // head and tail meet whenever the queue is empty or full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg != tail_reg) |-> ((waiting_reg != '0) && (waiting_reg != LVL_W'(QUEUE_DEPTH))))
        else $error("queue pointers out of step with fill level");

    // the note index never runs past the pattern's note count
    assert property (@(posedge aclk) disable iff (!aresetn)
        playing_reg |-> (idx_reg <= cur_cnt_reg))
        else $error("note index past note count");

    // a queued submit always leaves a pattern playing
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && ok) |=> (playing_reg && m_tdata[40]))
        else $error("accepted submit but player idle");
`endif

endmodule
